@@ design/i2cseq_pkg.sv @@
`default_nettype none

package i2cseq_pkg;

	// Default width of the start wait counter; the wait ends after 2**width polls.
	localparam int TIMEOUT_WIDTH_DEF = 16;

	// Word commands.
	localparam logic [1:0] CMD_BEGIN  = 2'd0;
	localparam logic [1:0] CMD_STATUS = 2'd1;
	localparam logic [1:0] CMD_TICK   = 2'd2;

	// Sequencer phases.
	localparam logic [2:0] PH_IDLE       = 3'd0;
	localparam logic [2:0] PH_WAIT_START = 3'd1;
	localparam logic [2:0] PH_WRITE      = 3'd2;
	localparam logic [2:0] PH_READ_SLA   = 3'd3;
	localparam logic [2:0] PH_READ_DATA  = 3'd4;

	// Engine status codes, divided by eight.
	localparam logic [4:0] ST_START     = 5'd1;
	localparam logic [4:0] ST_RSTART    = 5'd2;
	localparam logic [4:0] ST_SLAW_ACK  = 5'd3;
	localparam logic [4:0] ST_SLAW_NACK = 5'd4;
	localparam logic [4:0] ST_DATA_ACK  = 5'd5;
	localparam logic [4:0] ST_DATA_NACK = 5'd6;
	localparam logic [4:0] ST_ARB_LOST  = 5'd7;
	localparam logic [4:0] ST_SLAR_ACK  = 5'd8;
	localparam logic [4:0] ST_SLAR_NACK = 5'd9;
	localparam logic [4:0] ST_RX_ACK    = 5'd10;
	localparam logic [4:0] ST_RX_NACK   = 5'd11;

	// Engine actions.
	localparam logic [2:0] ACT_NONE       = 3'd0;
	localparam logic [2:0] ACT_START      = 3'd1;
	localparam logic [2:0] ACT_LOAD       = 3'd2;
	localparam logic [2:0] ACT_ACK        = 3'd3;
	localparam logic [2:0] ACT_NACK       = 3'd4;
	localparam logic [2:0] ACT_STOP       = 3'd5;
	localparam logic [2:0] ACT_STOP_START = 3'd6;
	localparam logic [2:0] ACT_CLEAR      = 3'd7;

	// Error codes.
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_BUS     = 2'd1;
	localparam logic [1:0] ERR_NACK    = 2'd2;
	localparam logic [1:0] ERR_BAD_LEN = 2'd3;

	// Largest number of internal address bytes.
	localparam logic [2:0] MAX_ADDR_BYTES = 3'd4;

endpackage

`default_nettype wire

@@ design/i2c_master_transaction_sequencer.sv @@
// Sequences one I2C master transaction on top of a byte-level bus engine. A begin word
// latches direction, 7-bit device address, 0 to 4 internal address bytes (sent most
// significant first) and a payload count, and asks for a START. Every later status or poll
// word gets exactly one result word: the engine action, the byte to load, any received byte,
// and done, error and busy flags. A read with an internal address writes the address first,
// then issues STOP followed by a new START. The START wait ends with a bus error after
// 2**TIMEOUT_WIDTH polls without a status. The block takes one word per clock while
// item_stall is low; each word passes an input register and a result register. Holding
// res_stall high backs up into item_stall once both registers are full.
`default_nettype none

module i2c_master_transaction_sequencer
	import i2cseq_pkg::*;
#(
	parameter int TIMEOUT_WIDTH = TIMEOUT_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input words.
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  cmd,
	input  wire logic        read_not_write,
	input  wire logic [6:0]  device_address,
	input  wire logic [31:0] internal_address,
	input  wire logic [2:0]  internal_address_bytes,
	input  wire logic [7:0]  byte_count,
	input  wire logic [4:0]  bus_status,
	input  wire logic [7:0]  bus_data,
	input  wire logic [7:0]  tx_byte,
	// Result words.
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [2:0]       action,
	output logic [7:0]       out_byte,
	output logic             tx_taken,
	output logic [7:0]       rx_byte,
	output logic             rx_valid,
	output logic             done_res,
	output logic [1:0]       error_code,
	output logic             busy_res
);

	// Input register.
	logic        valid_s1;
	logic [1:0]  cmd_s1;
	logic        rnw_s1;
	logic [6:0]  dev_s1;
	logic [31:0] iaddr_s1;
	logic [2:0]  nab_s1;
	logic [7:0]  cnt_s1;
	logic [4:0]  st_s1;
	logic [7:0]  data_s1;
	logic [7:0]  txb_s1;

	// Transaction state.
	logic [2:0]               phase_q;
	logic [6:0]               dev_q;
	logic [31:0]              iaddr_q;
	logic [2:0]               addr_left_q;
	logic [7:0]               pay_left_q;
	logic                     read_pend_q;
	logic [TIMEOUT_WIDTH-1:0] wait_q;

	// Next state and result.
	logic [2:0]               phase_d;
	logic [6:0]               dev_d;
	logic [31:0]              iaddr_d;
	logic [2:0]               addr_left_d;
	logic [7:0]               pay_left_d;
	logic                     read_pend_d;
	logic [TIMEOUT_WIDTH-1:0] wait_d;
	logic [2:0]               act_d;
	logic [7:0]               byte_d;
	logic                     taken_d;
	logic [7:0]               rx_d;
	logic                     rxv_d;
	logic                     done_d;
	logic [1:0]               err_d;

	logic       advance;
	logic       load_s1;
	logic [1:0] addr_sel;
	logic [7:0] addr_byte;
	logic [7:0] pay_dec;

	// The result register frees up when empty or when its word is taken.
	assign advance    = !res_valid || !res_stall;
	assign item_stall = valid_s1 && !advance;
	assign load_s1    = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1   <= cmd;
			rnw_s1   <= read_not_write;
			dev_s1   <= device_address;
			iaddr_s1 <= internal_address;
			nab_s1   <= internal_address_bytes;
			cnt_s1   <= byte_count;
			st_s1    <= bus_status;
			data_s1  <= bus_data;
			txb_s1   <= tx_byte;
		end
	end

	// Internal address bytes go out most significant first.
	assign addr_sel = addr_left_q[1:0] - 2'd1;

	always_comb begin
		case (addr_sel)
			2'd0:    addr_byte = iaddr_q[7:0];
			2'd1:    addr_byte = iaddr_q[15:8];
			2'd2:    addr_byte = iaddr_q[23:16];
			default: addr_byte = iaddr_q[31:24];
		endcase
	end

	// Read count after one received byte, held at zero.
	assign pay_dec = (pay_left_q != 8'd0) ? pay_left_q - 8'd1 : 8'd0;

	// One decision per word.
	always_comb begin
		phase_d     = phase_q;
		dev_d       = dev_q;
		iaddr_d     = iaddr_q;
		addr_left_d = addr_left_q;
		pay_left_d  = pay_left_q;
		read_pend_d = read_pend_q;
		wait_d      = wait_q;
		act_d       = ACT_NONE;
		byte_d      = 8'd0;
		taken_d     = 1'b0;
		rx_d        = 8'd0;
		rxv_d       = 1'b0;
		done_d      = 1'b0;
		err_d       = ERR_NONE;

		case (cmd_s1)
			CMD_BEGIN: begin
				if (phase_q == PH_IDLE) begin
					if (nab_s1 > MAX_ADDR_BYTES || (rnw_s1 && cnt_s1 == 8'd0)) begin
						done_d = 1'b1;
						err_d  = ERR_BAD_LEN;
					end else begin
						dev_d       = dev_s1;
						iaddr_d     = iaddr_s1;
						addr_left_d = nab_s1;
						pay_left_d  = cnt_s1;
						read_pend_d = rnw_s1;
						wait_d      = '0;
						phase_d     = PH_WAIT_START;
						act_d       = ACT_START;
					end
				end
			end
			CMD_STATUS: begin
				case (phase_q)
					PH_WAIT_START: begin
						if (st_s1 == ST_START || st_s1 == ST_RSTART) begin
							act_d = ACT_LOAD;
							if (addr_left_q != 3'd0 || !read_pend_q) begin
								byte_d  = {dev_q, 1'b0};
								phase_d = PH_WRITE;
							end else begin
								byte_d  = {dev_q, 1'b1};
								phase_d = PH_READ_SLA;
							end
						end else begin
							act_d   = ACT_CLEAR;
							done_d  = 1'b1;
							err_d   = ERR_BUS;
							phase_d = PH_IDLE;
						end
					end
					PH_WRITE: begin
						if (st_s1 == ST_SLAW_ACK || st_s1 == ST_DATA_ACK) begin
							if (addr_left_q != 3'd0) begin
								act_d       = ACT_LOAD;
								byte_d      = addr_byte;
								addr_left_d = addr_left_q - 3'd1;
							end else if (read_pend_q) begin
								act_d   = ACT_STOP_START;
								wait_d  = '0;
								phase_d = PH_WAIT_START;
							end else if (pay_left_q != 8'd0) begin
								act_d      = ACT_LOAD;
								byte_d     = txb_s1;
								taken_d    = 1'b1;
								pay_left_d = pay_left_q - 8'd1;
							end else begin
								act_d   = ACT_STOP;
								done_d  = 1'b1;
								phase_d = PH_IDLE;
							end
						end else if (st_s1 == ST_SLAW_NACK || st_s1 == ST_DATA_NACK) begin
							act_d   = ACT_STOP;
							done_d  = 1'b1;
							err_d   = ERR_NACK;
							phase_d = PH_IDLE;
						end else begin
							act_d   = ACT_CLEAR;
							done_d  = 1'b1;
							err_d   = ERR_BUS;
							phase_d = PH_IDLE;
						end
					end
					PH_READ_SLA: begin
						if (st_s1 == ST_SLAR_ACK) begin
							act_d   = (pay_left_q == 8'd1) ? ACT_NACK : ACT_ACK;
							phase_d = PH_READ_DATA;
						end else if (st_s1 == ST_SLAR_NACK) begin
							act_d   = ACT_STOP;
							done_d  = 1'b1;
							err_d   = ERR_NACK;
							phase_d = PH_IDLE;
						end else begin
							act_d   = ACT_CLEAR;
							done_d  = 1'b1;
							err_d   = ERR_BUS;
							phase_d = PH_IDLE;
						end
					end
					PH_READ_DATA: begin
						if (st_s1 == ST_RX_ACK || st_s1 == ST_RX_NACK) begin
							rx_d       = data_s1;
							rxv_d      = 1'b1;
							pay_left_d = pay_dec;
							if (st_s1 == ST_RX_NACK || pay_dec == 8'd0) begin
								act_d   = ACT_STOP;
								done_d  = 1'b1;
								phase_d = PH_IDLE;
							end else begin
								act_d = (pay_dec == 8'd1) ? ACT_NACK : ACT_ACK;
							end
						end else begin
							act_d   = ACT_CLEAR;
							done_d  = 1'b1;
							err_d   = ERR_BUS;
							phase_d = PH_IDLE;
						end
					end
					default: begin
						act_d = ACT_NONE;
					end
				endcase
			end
			CMD_TICK: begin
				// The poll that would carry the counter past its top ends the wait.
				if (phase_q == PH_WAIT_START) begin
					if (&wait_q) begin
						wait_d  = '0;
						done_d  = 1'b1;
						err_d   = ERR_BUS;
						phase_d = PH_IDLE;
					end else begin
						wait_d = wait_q + 1'b1;
					end
				end
			end
			default: begin
				act_d = ACT_NONE;
			end
		endcase
	end

	// State update, once for each word that moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			dev_q       <= 7'd0;
			iaddr_q     <= 32'd0;
			addr_left_q <= 3'd0;
			pay_left_q  <= 8'd0;
			read_pend_q <= 1'b0;
			wait_q      <= '0;
		end else if (valid_s1 && advance) begin
			phase_q     <= phase_d;
			dev_q       <= dev_d;
			iaddr_q     <= iaddr_d;
			addr_left_q <= addr_left_d;
			pay_left_q  <= pay_left_d;
			read_pend_q <= read_pend_d;
			wait_q      <= wait_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			action     <= act_d;
			out_byte   <= byte_d;
			tx_taken   <= taken_d;
			rx_byte    <= rx_d;
			rx_valid   <= rxv_d;
			done_res   <= done_d;
			error_code <= err_d;
			busy_res   <= (phase_d != PH_IDLE);
		end
	end

	// An error is only reported on the word that ends a transaction.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (error_code == ERR_NONE || done_res))
		else $error("error code without done");

	// A finished word reports busy exactly as the state it left behind.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> (busy_res == (phase_q != PH_IDLE)))
		else $error("busy flag disagrees with phase");

	// A payload byte is consumed only by a byte load.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && tx_taken) |-> (action == ACT_LOAD))
		else $error("tx byte taken without load");

	// A received byte comes with an acknowledge choice or a stop.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && rx_valid) |->
			(action == ACT_ACK || action == ACT_NACK || action == ACT_STOP))
		else $error("received byte with wrong action");

endmodule

`default_nettype wire
